[hw/rtl/oss_pkg.sv]
// ----------------------------------------------------------------------------
// oss_pkg
// Shared types and constants for the ordered set store.
// ----------------------------------------------------------------------------
package oss_pkg;

	localparam int CAPACITY = 16;
	localparam int VALUE_W  = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int COUNT_W  = 5;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic wr;
		logic shift;
	} cell_ctl_t;

endpackage

[hw/rtl/oss_cell.sv]
// ----------------------------------------------------------------------------
// oss_cell
// One slot of the store: compares, extends the match chain, shifts or loads.
// ----------------------------------------------------------------------------
module oss_cell (
	input  logic                          clk,
	input  logic signed [oss_pkg::VALUE_W-1:0] value,
	input  logic                          occupied,
	input  oss_pkg::cell_ctl_t            ctl,
	input  logic signed [oss_pkg::VALUE_W-1:0] next_value,
	input  logic                          prefix_in,
	output logic                          prefix_out,
	output logic signed [oss_pkg::VALUE_W-1:0] slot_value
);
	import oss_pkg::*;

	logic signed [VALUE_W-1:0] slot_q;
	logic                      match;

	assign match      = occupied && (slot_q == value);
	assign prefix_out = prefix_in | match;
	assign slot_value = slot_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			slot_q <= value;
		end else if (ctl.shift && prefix_out) begin
			slot_q <= next_value;
		end
	end

endmodule

[hw/rtl/ordered_set_store.sv]
// ----------------------------------------------------------------------------
// ordered_set_store
// Insertion-ordered set of distinct values held in a chain of slot cells.
// ----------------------------------------------------------------------------
// the result is registered and shows in the cycle after the input transfer
// throughput: one command per cycle while the result side takes transfers
// the match chain runs combinationally through all slot cells
// reset: arst_n clears the member count and the result valid at once
// slot contents are undefined after reset and need no clearing pass
module ordered_set_store (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         cmd,
	input  logic signed [oss_pkg::VALUE_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               hit,
	output logic                               overflow,
	output logic [oss_pkg::COUNT_W-1:0]        count
);
	import oss_pkg::*;

	logic                      out_valid_q;
	logic                      hit_q;
	logic                      overflow_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_next;

	logic                      accept;
	logic                      found;
	logic                      full;
	logic                      do_add;
	logic                      do_remove;
	logic                      res_hit;
	logic                      res_ovf;

	logic                      prefix [CAPACITY+1];
	logic signed [VALUE_W-1:0] slot_value [CAPACITY];
	cell_ctl_t                 ctl [CAPACITY];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign found    = prefix[CAPACITY];
	assign prefix[0] = 1'b0;

	always_comb begin
		do_add     = 1'b0;
		do_remove  = 1'b0;
		res_hit    = 1'b0;
		res_ovf    = 1'b0;
		count_next = count_q;
		unique case (cmd_t'(cmd))
			CMD_ADD: begin
				if (!found && !full) begin
					do_add     = accept;
					res_hit    = 1'b1;
					count_next = count_q + CNT_W'(1);
				end
				res_ovf = !found && full;
			end
			CMD_REMOVE: begin
				if (found) begin
					do_remove  = accept;
					res_hit    = 1'b1;
					count_next = count_q - CNT_W'(1);
				end
			end
			CMD_QUERY: begin
				res_hit = found;
			end
			CMD_CLEAR: begin
				count_next = '0;
			end
			default: begin
				count_next = count_q;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] nxt;

		if (i == CAPACITY - 1) begin : g_last
			assign nxt = slot_value[i];
		end else begin : g_mid
			assign nxt = slot_value[i+1];
		end

		assign ctl[i].wr    = do_add && (count_q == CNT_W'(i));
		assign ctl[i].shift = do_remove;

		oss_cell u_cell (
			.clk        (clk),
			.value      (value),
			.occupied   (CNT_W'(i) < count_q),
			.ctl        (ctl[i]),
			.next_value (nxt),
			.prefix_in  (prefix[i]),
			.prefix_out (prefix[i+1]),
			.slot_value (slot_value[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q      <= res_hit;
			overflow_q <= res_ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign overflow  = overflow_q;
	assign count     = COUNT_W'(count_q);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("member count beyond capacity");

	a_ovf_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && overflow_q))
		else $error("overflow and hit together");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == CMD_CLEAR) |=> count_q == '0)
		else $error("clear left members");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_add |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("add did not grow count");

endmodule

[tb/ordered_set_store_test.sv]
// ----------------------------------------------------------------------------
// ordered_set_store_test
// Self-checking bench for the insertion-ordered set store. A scoreboard keeps
// its own copy of the member slots and count, predicts hit, overflow and count
// for every command transfer, and compares each result transfer in order.
// Directed commands cover the value extremes and the corner cases. Random
// phases then draw values from small pools so adds, removes and queries often
// hit and the store often fills up. Both sides idle at random.
// ----------------------------------------------------------------------------
module ordered_set_store_test;

	import oss_pkg::*;

	typedef struct packed {
		logic               hit;
		logic               overflow;
		logic [COUNT_W-1:0] count;
	} reply_t;

	class member_scoreboard;
		logic signed [VALUE_W-1:0] slots[CAPACITY];
		int unsigned               n_members;
		reply_t                    pending_replies[$];
		int unsigned               errors;

		function new();
			n_members = 0;
			errors = 0;
		endfunction

		function int find_slot(logic signed [VALUE_W-1:0] v);
			for (int i = 0; i < n_members; i++)
				if (slots[i] === v)
					return i;
			return -1;
		endfunction

		function void note_command(cmd_t op, logic signed [VALUE_W-1:0] v);
			reply_t r;
			int pos;
			r = '0;
			pos = find_slot(v);
			case (op)
				CMD_ADD: begin
					if (pos < 0) begin
						if (n_members < CAPACITY) begin
							slots[n_members] = v;
							n_members++;
							r.hit = 1'b1;
						end else begin
							r.overflow = 1'b1;
						end
					end
				end
				CMD_REMOVE: begin
					if (pos >= 0) begin
						for (int j = pos; j + 1 < n_members; j++)
							slots[j] = slots[j + 1];
						n_members--;
						r.hit = 1'b1;
					end
				end
				CMD_QUERY: r.hit = (pos >= 0);
				default: n_members = 0;
			endcase
			r.count = n_members[COUNT_W-1:0];
			pending_replies.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic h, logic o, logic [COUNT_W-1:0] c);
			reply_t exp;
			if (pending_replies.size() == 0) begin
				report_mismatch("result transfer with no command pending");
			end else begin
				exp = pending_replies.pop_front();
				if (h !== exp.hit)
					report_mismatch($sformatf("hit %b, expected %b", h, exp.hit));
				if (o !== exp.overflow)
					report_mismatch($sformatf("overflow %b, expected %b", o, exp.overflow));
				if (c !== exp.count)
					report_mismatch($sformatf("count %0d, expected %0d", c, exp.count));
			end
		endtask
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                cmd = CMD_QUERY;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      hit;
	logic                      overflow;
	logic [COUNT_W-1:0]        count;

	member_scoreboard sb = new();

	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit long_hold_req = 1'b0;

	logic signed [VALUE_W-1:0] value_pool[48];

	ordered_set_store u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit      (hit),
		.overflow (overflow),
		.count    (count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_command(cmd_t'(cmd), value);
			if (out_valid && !out_stall)
				sb.check_result(hit, overflow, count);
		end
	end

	// one command transfer, after a random gap unless the sender runs quiet
	task send_command(cmd_t op, logic signed [VALUE_W-1:0] v);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		value <= v;
		do @(posedge clk); while (in_stall);
	endtask

	task send_random_command(int unsigned pool_size);
		int unsigned pick;
		logic signed [VALUE_W-1:0] v;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0)
			v = $urandom;
		else
			v = value_pool[$urandom_range(0, pool_size - 1)];
		if (pick < 45)
			send_command(CMD_ADD, v);
		else if (pick < 70)
			send_command(CMD_REMOVE, v);
		else if (pick < 97)
			send_command(CMD_QUERY, v);
		else
			send_command(CMD_CLEAR, $urandom);
	endtask

	// result side: random stalls, quiet stretches, one long hold-off on request
	initial begin
		int unsigned wait_cycles;
		int unsigned taken;
		taken = 0;
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				wait_cycles = 300;
			end else if (rx_quiet) begin
				wait_cycles = 0;
			end else begin
				wait_cycles = $urandom_range(0, 10);
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			taken++;
			if (taken % 50 == 0)
				rx_quiet = ($urandom_range(0, 2) == 0);
		end
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int unsigned pool_size;
		int unsigned waited;
		value_pool[0] = 32'sh8000_0000;
		value_pool[1] = 32'sh7fff_ffff;
		value_pool[2] = 32'sh0000_0000;
		value_pool[3] = 32'shffff_ffff;
		for (int i = 4; i < 48; i++)
			value_pool[i] = $urandom;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, duplicates, misses, removal from the middle and the front
		send_command(CMD_QUERY, 32'sh0000_0000);
		send_command(CMD_REMOVE, 32'sh0000_0005);
		send_command(CMD_ADD, 32'sh8000_0000);
		send_command(CMD_ADD, 32'sh7fff_ffff);
		send_command(CMD_ADD, 32'sh0000_0000);
		send_command(CMD_ADD, 32'shffff_ffff);
		send_command(CMD_ADD, 32'sh8000_0000);
		send_command(CMD_QUERY, 32'sh7fff_ffff);
		send_command(CMD_REMOVE, 32'sh0000_0000);
		send_command(CMD_QUERY, 32'shffff_ffff);
		send_command(CMD_REMOVE, 32'sh8000_0000);
		send_command(CMD_CLEAR, 32'sh5a5a_a5a5);
		send_command(CMD_QUERY, 32'sh7fff_ffff);
		// fill up, then refused add, add of a present member, drop the last one
		for (int i = 0; i < CAPACITY; i++)
			send_command(CMD_ADD, value_pool[4 + i]);
		send_command(CMD_ADD, 32'sh0000_0001);
		send_command(CMD_ADD, value_pool[4]);
		send_command(CMD_REMOVE, value_pool[4 + CAPACITY - 1]);
		send_command(CMD_CLEAR, 32'sh0000_0000);

		for (int phase = 0; phase < 9; phase++) begin
			case ($urandom_range(0, 3))
				0: pool_size = 4;
				1: pool_size = 16;
				2: pool_size = 20;
				default: pool_size = 48;
			endcase
			tx_quiet = ($urandom_range(0, 3) == 0);
			if (phase == 3) begin
				tx_quiet = 1'b1;
				long_hold_req = 1'b1;
			end
			for (int k = 0; k < 150; k++)
				send_random_command(pool_size);
		end
		in_valid <= 1'b0;

		waited = 0;
		while (sb.pending_replies.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);

		if (sb.errors == 0 && sb.pending_replies.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
